// ----- sv/ppc_pkg.sv -----
// Shared types and constants for the playback position clock.
// Used by every module of the block; no dependencies.
package ppc_pkg;

  localparam int unsigned NS_W    = 63;
  localparam int unsigned POS_W   = 48;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned SR_W    = 20;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned GRACE_W = 32;
  localparam int unsigned CFG_IW  = 2;
  localparam int unsigned CFG_DW  = 32;
  localparam int unsigned ACC_W   = 84;
  localparam int unsigned MPL_W   = 20;

  localparam logic [RATE_W-1:0]  RATE_MIN    = 16'd410;
  localparam logic [RATE_W-1:0]  RATE_MAX    = 16'd32768;
  localparam logic [RATE_W-1:0]  RATE_RST    = 16'd4096;
  localparam logic [SR_W-1:0]    SR_RST      = 20'd48000;
  localparam logic [GRACE_W-1:0] GRACE_RST   = 32'd500000000;
  localparam logic [MPL_W-1:0]   US_PER_S    = 20'd1000000;
  // ns / 1000 = (ns >> 3) / 125
  localparam int unsigned        US_SHIFT    = 3;
  // ns * rate / 4096000 = ((ns * rate) >> 15) / 125
  localparam logic [SR_W-1:0]    WALL_DIV    = 20'd125;
  localparam int unsigned        WALL_SHIFT  = 15;
  localparam int unsigned        Q_SHIFT     = 12;
  // floor(x / 125) = (x * CDIV_RECIP) >> CDIV_SHIFT for x below 2^23
  localparam logic [23:0]        CDIV_RECIP  = 24'd8589935;
  localparam int unsigned        CDIV_SHIFT  = 30;
  localparam int unsigned        CDIV_DIGIT  = 16;
  localparam int unsigned        CDIV_STEPS  = 4;

  localparam logic [CFG_IW-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_RATE        = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_GRACE       = 2'd2;

  typedef enum logic [2:0] {
    CMD_SEEK      = 3'd0,
    CMD_START     = 3'd1,
    CMD_PAUSE     = 3'd2,
    CMD_STOP      = 3'd3,
    CMD_SAMPLES   = 3'd4,
    CMD_SYNC      = 3'd5,
    CMD_READ_CUR  = 3'd6,
    CMD_READ_PROD = 3'd7
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [NS_W-1:0]  now;
    logic [POS_W-1:0] pos;    // clamped, never above the position limit
    logic [CNT_W-1:0] count;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;
  } cfg_wr_t;

endpackage

// ----- sv/ppc_front.sv -----
// Front end: decodes the command and clamps the position of each input item.
// Depends on ppc_pkg.
module ppc_front #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   cmd_i,
  input  logic [ppc_pkg::NS_W-1:0]     now_ns_i,
  input  logic signed [ppc_pkg::POS_W-1:0] position_us_i,
  input  logic [ppc_pkg::CNT_W-1:0]    sample_count_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output ppc_pkg::item_t               item_o
);

  localparam logic [ppc_pkg::POS_W-1:0] TMAX48 = (TIME_BITS >= ppc_pkg::POS_W) ? '1 :
    ((ppc_pkg::POS_W'(1) << TIME_BITS) - ppc_pkg::POS_W'(1));

  logic [ppc_pkg::POS_W-1:0] pos_raw;

  assign pos_raw    = $unsigned(position_us_i);
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.cmd   = ppc_pkg::cmd_e'(cmd_i);
    item_o.now   = now_ns_i;
    item_o.count = sample_count_i;
    if (pos_raw[ppc_pkg::POS_W-1]) begin
      item_o.pos = '0;
    end else if (pos_raw > TMAX48) begin
      item_o.pos = TMAX48;
    end else begin
      item_o.pos = pos_raw;
    end
  end

endmodule

// ----- sv/ppc_fifo.sv -----
// Two-entry item queue between front end and execution engine.
// Depends on ppc_pkg.
module ppc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ppc_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ppc_pkg::item_t item_o
);

  ppc_pkg::item_t mem_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- sv/ppc_back.sv -----
// Execution engine: clock state, configuration registers, shift-add multiplier,
// restoring divider, constant divider, command sequencer and output register.
// Depends on ppc_pkg.
module ppc_back #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ppc_pkg::cfg_wr_t           cfg_i,
  input  logic                       item_valid_i,
  input  ppc_pkg::item_t             item_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ppc_pkg::POS_W-1:0]  time_us_o,
  output logic                       is_answer_o,
  output logic                       running_now_o
);

  localparam int unsigned TB    = TIME_BITS;
  localparam int unsigned AW    = ppc_pkg::ACC_W;
  localparam int unsigned NW    = ppc_pkg::NS_W;
  localparam int unsigned DW    = ppc_pkg::SR_W;
  localparam int unsigned CDW   = ppc_pkg::CDIV_DIGIT * ppc_pkg::CDIV_STEPS;
  localparam logic [TB-1:0] TMAX = '1;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_CDIV, S_FIN} state_e;
  typedef enum logic [1:0] {J_WALL, J_ANCH, J_PROD_A, J_PROD_B} job_e;

  function automatic logic [TB-1:0] sat_add(logic [TB-1:0] a, logic [TB-1:0] b);
    logic [TB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TB] ? TMAX : s[TB-1:0];
  endfunction

  function automatic logic [TB-1:0] sat_acc(logic [AW-1:0] x);
    return (x > AW'(TMAX)) ? TMAX : x[TB-1:0];
  endfunction

  // configuration
  logic [ppc_pkg::SR_W-1:0]    sr_q;
  logic [ppc_pkg::RATE_W-1:0]  rate_q;
  logic [ppc_pkg::GRACE_W-1:0] grace_q;

  // clock state
  logic          running_q;
  logic [TB-1:0] paused_q;
  logic [TB-1:0] start_q;
  logic [TB-1:0] rendered_q;
  logic          anch_valid_q;
  logic [TB-1:0] anch_played_q;
  logic [NW-1:0] anch_wall_q;
  logic [NW-1:0] start_wall_q;
  logic [TB-1:0] last_q;

  // engine
  state_e                     state_q;
  job_e                       job_q;
  ppc_pkg::cmd_e              cmd_q;
  logic [AW-1:0]              mcand_q;
  logic [ppc_pkg::MPL_W-1:0]  mplier_q;
  logic [AW-1:0]              prod_q;
  logic [AW-1:0]              num_q;
  logic [DW-1:0]              rem_q;
  logic [DW-1:0]              den_q;
  logic [6:0]                 cnt_q;
  logic [TB-1:0]              x_q;

  // output register
  logic                      out_valid_q;
  logic [ppc_pkg::POS_W-1:0] time_q;
  logic                      ans_q;
  logic                      run_q;

  logic [ppc_pkg::RATE_W-1:0] rate_eff;
  logic [DW-1:0]              sr_eff;
  logic [TB-1:0]              pos_tb;
  logic [NW-1:0]              since;
  logic [NW-1:0]              wall_d;
  logic [NW-1:0]              anch_diff;
  logic [DW:0]                div_sh;
  logic [DW:0]                div_sub;
  logic                       div_ge;
  logic [TB-1:0]              fin_pos;
  logic [TB-1:0]              fin_last;
  logic [TB-1:0]              div_quo;
  logic [22:0]                cd_x;
  logic [46:0]                cd_prod;
  logic [15:0]                cd_qd;
  logic [6:0]                 cd_r;

  assign rate_eff = (rate_q < ppc_pkg::RATE_MIN) ? ppc_pkg::RATE_MIN :
                    (rate_q > ppc_pkg::RATE_MAX) ? ppc_pkg::RATE_MAX : rate_q;
  assign sr_eff   = (sr_q == '0) ? DW'(1) : sr_q;
  assign pos_tb   = TB'(item_i.pos);
  assign since    = item_i.now - start_wall_q;
  assign wall_d   = since - NW'(grace_q);
  assign anch_diff = (item_i.now > anch_wall_q) ? (item_i.now - anch_wall_q) : '0;
  assign div_sh   = {rem_q, num_q[AW-1]};
  assign div_ge   = (div_sh >= {1'b0, den_q});
  assign div_sub  = div_sh - {1'b0, den_q};
  assign div_quo  = sat_acc(num_q);
  assign fin_pos  = sat_add(start_q, x_q);
  assign fin_last = (fin_pos > last_q) ? fin_pos : last_q;

  // divide by 125 one 16-bit digit per cycle, remainder below 125
  assign cd_x    = {rem_q[6:0], num_q[CDW-1 -: 16]};
  assign cd_prod = 47'(cd_x) * 47'(ppc_pkg::CDIV_RECIP);
  assign cd_qd   = cd_prod[ppc_pkg::CDIV_SHIFT +: 16];
  assign cd_r    = 7'(cd_x - 23'(cd_qd) * 23'(ppc_pkg::WALL_DIV));

  assign pop_o = (state_q == S_IDLE) && item_valid_i && (!out_valid_q || out_ready_i);

  assign out_valid_o   = out_valid_q;
  assign time_us_o     = time_q;
  assign is_answer_o   = ans_q;
  assign running_now_o = run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q          <= ppc_pkg::SR_RST;
      rate_q        <= ppc_pkg::RATE_RST;
      grace_q       <= ppc_pkg::GRACE_RST;
      running_q     <= 1'b0;
      paused_q      <= '0;
      start_q       <= '0;
      rendered_q    <= '0;
      anch_valid_q  <= 1'b0;
      anch_played_q <= '0;
      anch_wall_q   <= '0;
      start_wall_q  <= '0;
      last_q        <= '0;
      state_q       <= S_IDLE;
      job_q         <= J_WALL;
      cmd_q         <= ppc_pkg::CMD_SEEK;
      mcand_q       <= '0;
      mplier_q      <= '0;
      prod_q        <= '0;
      num_q         <= '0;
      rem_q         <= '0;
      den_q         <= '0;
      cnt_q         <= '0;
      x_q           <= '0;
      out_valid_q   <= 1'b0;
      time_q        <= '0;
      ans_q         <= 1'b0;
      run_q         <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          ppc_pkg::CFG_SAMPLE_RATE: sr_q    <= cfg_i.data[ppc_pkg::SR_W-1:0];
          ppc_pkg::CFG_RATE:        rate_q  <= cfg_i.data[ppc_pkg::RATE_W-1:0];
          ppc_pkg::CFG_GRACE:       grace_q <= cfg_i.data;
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            cmd_q <= item_i.cmd;
            unique case (item_i.cmd)
              ppc_pkg::CMD_SEEK: begin
                paused_q      <= pos_tb;
                start_q       <= pos_tb;
                rendered_q    <= '0;
                running_q     <= 1'b0;
                anch_valid_q  <= 1'b0;
                anch_played_q <= '0;
                anch_wall_q   <= '0;
                last_q        <= pos_tb;
                out_valid_q   <= 1'b1;
                time_q        <= '0;
                ans_q         <= 1'b0;
                run_q         <= 1'b0;
              end
              ppc_pkg::CMD_START: begin
                start_q       <= paused_q;
                rendered_q    <= '0;
                anch_valid_q  <= 1'b0;
                anch_played_q <= '0;
                anch_wall_q   <= '0;
                start_wall_q  <= item_i.now;
                last_q        <= paused_q;
                running_q     <= 1'b1;
                out_valid_q   <= 1'b1;
                time_q        <= '0;
                ans_q         <= 1'b0;
                run_q         <= 1'b1;
              end
              ppc_pkg::CMD_SAMPLES: begin
                if (item_i.count != '0) begin
                  rendered_q <= sat_add(rendered_q, TB'(item_i.count));
                end
                out_valid_q <= 1'b1;
                time_q      <= '0;
                ans_q       <= 1'b0;
                run_q       <= running_q;
              end
              ppc_pkg::CMD_SYNC: begin
                anch_played_q <= pos_tb;
                anch_wall_q   <= item_i.now;
                anch_valid_q  <= 1'b1;
                out_valid_q   <= 1'b1;
                time_q        <= '0;
                ans_q         <= 1'b0;
                run_q         <= running_q;
              end
              ppc_pkg::CMD_READ_PROD: begin
                if (!running_q) begin
                  out_valid_q <= 1'b1;
                  time_q      <= ppc_pkg::POS_W'(paused_q);
                  ans_q       <= 1'b1;
                  run_q       <= 1'b0;
                end else begin
                  job_q    <= J_PROD_A;
                  mcand_q  <= AW'(rendered_q);
                  mplier_q <= ppc_pkg::US_PER_S;
                  prod_q   <= '0;
                  state_q  <= S_MUL;
                end
              end
              default: begin
                // pause, stop, read current
                if (item_i.cmd == ppc_pkg::CMD_STOP) begin
                  rendered_q <= '0;
                end
                if (!running_q) begin
                  out_valid_q <= 1'b1;
                  time_q      <= (item_i.cmd == ppc_pkg::CMD_READ_CUR) ?
                                 ppc_pkg::POS_W'(paused_q) : '0;
                  ans_q       <= (item_i.cmd == ppc_pkg::CMD_READ_CUR);
                  run_q       <= 1'b0;
                end else if (anch_valid_q) begin
                  job_q   <= J_ANCH;
                  num_q   <= AW'(anch_diff >> ppc_pkg::US_SHIFT);
                  rem_q   <= '0;
                  cnt_q   <= 7'(ppc_pkg::CDIV_STEPS);
                  state_q <= S_CDIV;
                end else if ((item_i.now > start_wall_q) && (since > NW'(grace_q))) begin
                  job_q    <= J_WALL;
                  mcand_q  <= AW'(wall_d);
                  mplier_q <= ppc_pkg::MPL_W'(rate_eff);
                  prod_q   <= '0;
                  state_q  <= S_MUL;
                end else begin
                  x_q     <= '0;
                  state_q <= S_FIN;
                end
              end
            endcase
          end
        end

        S_MUL: begin
          if (mplier_q == '0) begin
            unique case (job_q)
              J_WALL: begin
                num_q   <= prod_q >> ppc_pkg::WALL_SHIFT;
                rem_q   <= '0;
                cnt_q   <= 7'(ppc_pkg::CDIV_STEPS);
                state_q <= S_CDIV;
              end
              J_PROD_A: begin
                num_q   <= prod_q;
                den_q   <= sr_eff;
                rem_q   <= '0;
                cnt_q   <= 7'(AW);
                state_q <= S_DIV;
              end
              default: begin
                x_q     <= sat_acc(prod_q >> ppc_pkg::Q_SHIFT);
                state_q <= S_FIN;
              end
            endcase
          end else begin
            if (mplier_q[0]) begin
              prod_q <= prod_q + mcand_q;
            end
            mcand_q  <= mcand_q << 1;
            mplier_q <= mplier_q >> 1;
          end
        end

        S_DIV: begin
          if (cnt_q == '0) begin
            job_q    <= J_PROD_B;
            mcand_q  <= AW'(div_quo);
            mplier_q <= ppc_pkg::MPL_W'(rate_eff);
            prod_q   <= '0;
            state_q  <= S_MUL;
          end else begin
            rem_q <= div_ge ? div_sub[DW-1:0] : div_sh[DW-1:0];
            num_q <= {num_q[AW-2:0], div_ge};
            cnt_q <= cnt_q - 7'd1;
          end
        end

        S_CDIV: begin
          if (cnt_q == '0) begin
            unique case (job_q)
              J_WALL: begin
                x_q     <= div_quo;
                state_q <= S_FIN;
              end
              default: begin
                mcand_q  <= AW'(sat_add(anch_played_q, div_quo));
                mplier_q <= ppc_pkg::MPL_W'(rate_eff);
                prod_q   <= '0;
                state_q  <= S_MUL;
              end
            endcase
          end else begin
            rem_q <= DW'(cd_r);
            num_q <= AW'({num_q[CDW-17:0], cd_qd});
            cnt_q <= cnt_q - 7'd1;
          end
        end

        S_FIN: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
          if (cmd_q == ppc_pkg::CMD_READ_PROD) begin
            time_q <= ppc_pkg::POS_W'(fin_pos);
            ans_q  <= 1'b1;
            run_q  <= running_q;
          end else begin
            last_q <= fin_last;
            if (cmd_q == ppc_pkg::CMD_READ_CUR) begin
              time_q <= ppc_pkg::POS_W'(fin_last);
              ans_q  <= 1'b1;
              run_q  <= running_q;
            end else begin
              paused_q  <= fin_last;
              running_q <= 1'b0;
              time_q    <= '0;
              ans_q     <= 1'b0;
              run_q     <= 1'b0;
            end
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/playback_position_clock.sv -----
// Top level of the playback position clock: front end, item queue, engine.
// Depends on ppc_pkg, ppc_front, ppc_fifo and ppc_back.
//
// Media playhead clock: one command per item (seek, start, pause, stop, add
// rendered samples, sink sync, read current position, read produced position),
// exactly one result item per command item. Seek, start, sample, sync, and any
// command while the clock is stopped finish in the idle state, which writes the
// result register as it takes the item. Pause, stop and the current-position read
// while running go straight to the finish state inside the grace period when no
// sync anchor is set; otherwise they take a shift-add multiply by the rate (one
// multiplier bit per cycle) and a divide by 125 done one 16-bit digit per cycle
// with a reciprocal multiply. The produced-position read while running takes a
// shift-add multiply by one million, a restoring divide by the sample rate and a
// multiply by the rate. A two-entry queue keeps taking items while the engine
// works, until it is full; the engine takes the next item only once the output
// register is free or being read. Configuration is always ready.
module playback_position_clock #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ppc_pkg::CFG_IW-1:0]        cfg_index_i,
  input  logic [ppc_pkg::CFG_DW-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        cmd_i,
  input  logic [ppc_pkg::NS_W-1:0]          now_ns_i,
  input  logic signed [ppc_pkg::POS_W-1:0]  position_us_i,
  input  logic [ppc_pkg::CNT_W-1:0]         sample_count_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ppc_pkg::POS_W-1:0]         time_us_o,
  output logic                              is_answer_o,
  output logic                              running_now_o
);

  ppc_pkg::item_t   f_item;
  ppc_pkg::item_t   q_item;
  ppc_pkg::cfg_wr_t cfg_wr;
  logic             q_full;
  logic             q_push;
  logic             q_valid;
  logic             q_pop;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  ppc_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .now_ns_i       (now_ns_i),
    .position_us_i  (position_us_i),
    .sample_count_i (sample_count_i),
    .q_full_i       (q_full),
    .push_o         (q_push),
    .item_o         (f_item)
  );

  ppc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  ppc_back #(
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_wr),
    .item_valid_i  (q_valid),
    .item_i        (q_item),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .time_us_o     (time_us_o),
    .is_answer_o   (is_answer_o),
    .running_now_o (running_now_o)
  );

endmodule

// ----- sim/ppc_checker.sv -----
// Checker for the playback position clock: watches the config, command and result
// channels, predicts every result item and compares it field by field.
// Depends on ppc_pkg for widths, config indexes and command codes.
module ppc_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [ppc_pkg::CFG_IW-1:0]       cfg_index_i,
  input  logic [ppc_pkg::CFG_DW-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [2:0]                       cmd_i,
  input  logic [ppc_pkg::NS_W-1:0]         now_ns_i,
  input  logic [ppc_pkg::POS_W-1:0]        position_us_i,
  input  logic [ppc_pkg::CNT_W-1:0]        sample_count_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [ppc_pkg::POS_W-1:0]        time_us_i,
  input  logic                             is_answer_i,
  input  logic                             running_now_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  localparam logic [63:0] TMAX = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [ppc_pkg::POS_W-1:0] time_us;
    logic                      is_answer;
    logic                      running_now;
  } answer_t;

  answer_t answers_due[$];

  logic [ppc_pkg::SR_W-1:0]    sr_q;
  logic [ppc_pkg::RATE_W-1:0]  rate_q;
  logic [ppc_pkg::GRACE_W-1:0] grace_q;

  logic        running_q;
  logic [63:0] paused_pos_q, start_pos_q, rendered_q;
  logic        anchor_ok_q;
  logic [63:0] anchor_played_q, anchor_wall_q, start_wall_q, last_rep_q;

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] x, y;
    x = (a > TMAX) ? TMAX : a;
    y = (b > TMAX) ? TMAX : b;
    return (x > TMAX - y) ? TMAX : x + y;
  endfunction

  function automatic logic [63:0] speed();
    if (rate_q < ppc_pkg::RATE_MIN) return 64'(ppc_pkg::RATE_MIN);
    if (rate_q > ppc_pkg::RATE_MAX) return 64'(ppc_pkg::RATE_MAX);
    return 64'(rate_q);
  endfunction

  function automatic logic [63:0] q12_scale(input logic [63:0] a, input logic [63:0] r);
    logic [63:0] q, m;
    q = a >> 12;
    m = a & 64'd4095;
    if (q > TMAX / r) return TMAX;
    return sat_sum(q * r, (m * r) >> 12);
  endfunction

  function automatic logic [63:0] playhead_now(input logic [63:0] now);
    logic [63:0] pos, r, since, d, interp, played;
    r = speed();
    if (!running_q) return paused_pos_q;
    if (!anchor_ok_q) begin
      pos = start_pos_q;
      if (now > start_wall_q) begin
        since = now - start_wall_q;
        if (since > 64'(grace_q)) begin
          d = since - 64'(grace_q);
          pos = sat_sum(start_pos_q, sat_sum((d / 64'd4096000) * r,
                                             ((d % 64'd4096000) * r) / 64'd4096000));
        end
      end
    end else begin
      interp = (now > anchor_wall_q) ? (now - anchor_wall_q) / 64'd1000 : 64'd0;
      played = sat_sum(anchor_played_q, interp);
      pos = sat_sum(start_pos_q, q12_scale(played, r));
    end
    if (pos > last_rep_q) last_rep_q = pos;
    return last_rep_q;
  endfunction

  function automatic logic [63:0] produced_now();
    logic [63:0] sr, q, rem, us;
    if (!running_q) return paused_pos_q;
    sr = (sr_q == '0) ? 64'd1 : 64'(sr_q);
    q = rendered_q / sr;
    rem = rendered_q % sr;
    if (q > TMAX / 64'd1000000) us = TMAX;
    else us = sat_sum(q * 64'd1000000, (rem * 64'd1000000) / sr);
    return sat_sum(start_pos_q, q12_scale(us, speed()));
  endfunction

  function automatic answer_t advance_playhead(input logic [2:0] c, input logic [62:0] t,
                                               input logic [47:0] p, input logic [15:0] n);
    answer_t     a;
    logic [63:0] now, pos, v;
    now = 64'(t);
    pos = p[47] ? 64'd0 : 64'(p);
    a.time_us = '0;
    a.is_answer = 1'b0;
    case (ppc_pkg::cmd_e'(c)) inside
      ppc_pkg::CMD_SEEK: begin
        paused_pos_q = pos;
        start_pos_q = pos;
        rendered_q = '0;
        running_q = 1'b0;
        anchor_ok_q = 1'b0;
        anchor_played_q = '0;
        anchor_wall_q = '0;
        last_rep_q = pos;
      end
      ppc_pkg::CMD_START: begin
        start_pos_q = paused_pos_q;
        rendered_q = '0;
        anchor_ok_q = 1'b0;
        anchor_played_q = '0;
        anchor_wall_q = '0;
        start_wall_q = now;
        last_rep_q = start_pos_q;
        running_q = 1'b1;
      end
      ppc_pkg::CMD_PAUSE, ppc_pkg::CMD_STOP: begin
        if (running_q) begin
          paused_pos_q = playhead_now(now);
          running_q = 1'b0;
        end
        if (ppc_pkg::cmd_e'(c) == ppc_pkg::CMD_STOP) rendered_q = '0;
      end
      ppc_pkg::CMD_SAMPLES: if (n != '0) rendered_q = sat_sum(rendered_q, 64'(n));
      ppc_pkg::CMD_SYNC: begin
        anchor_played_q = pos;
        anchor_wall_q = now;
        anchor_ok_q = 1'b1;
      end
      ppc_pkg::CMD_READ_CUR: begin
        v = playhead_now(now);
        a.time_us = v[47:0];
        a.is_answer = 1'b1;
      end
      default: begin
        v = produced_now();
        a.time_us = v[47:0];
        a.is_answer = 1'b1;
      end
    endcase
    a.running_now = running_q;
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got, want;
    int      errs;
    if (!rst_ni) begin
      sr_q <= ppc_pkg::SR_RST;
      rate_q <= ppc_pkg::RATE_RST;
      grace_q <= ppc_pkg::GRACE_RST;
      running_q = 1'b0;
      paused_pos_q = '0;
      start_pos_q = '0;
      rendered_q = '0;
      anchor_ok_q = 1'b0;
      anchor_played_q = '0;
      anchor_wall_q = '0;
      start_wall_q = '0;
      last_rep_q = '0;
      answers_due.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      errs = 0;
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ppc_pkg::CFG_SAMPLE_RATE: sr_q <= cfg_data_i[ppc_pkg::SR_W-1:0];
          ppc_pkg::CFG_RATE:        rate_q <= cfg_data_i[ppc_pkg::RATE_W-1:0];
          ppc_pkg::CFG_GRACE:       grace_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (answers_due.size() == 0) begin
          $error("result item with nothing expected");
          errs++;
        end else begin
          want = answers_due.pop_front();
          got.time_us = time_us_i;
          got.is_answer = is_answer_i;
          got.running_now = running_now_i;
          if (got.time_us !== want.time_us) begin
            $error("time_us: expected %0d, got %0d", want.time_us, got.time_us);
            errs++;
          end
          if (got.is_answer !== want.is_answer) begin
            $error("is_answer: expected %0b, got %0b", want.is_answer, got.is_answer);
            errs++;
          end
          if (got.running_now !== want.running_now) begin
            $error("running_now: expected %0b, got %0b", want.running_now, got.running_now);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        answers_due.push_back(advance_playhead(cmd_i, now_ns_i, position_us_i,
                                               sample_count_i));
      fail_count_o <= fail_count_o + errs;
      pending_o <= answers_due.size();
    end
  end

endmodule

// ----- sim/playback_position_clock_tb.sv -----
// Testbench top for the playback position clock: clock, reset, command stimulus,
// result back-pressure, config phases, watchdog and verdict.
// Depends on ppc_pkg, playback_position_clock and ppc_checker.
module playback_position_clock_tb;

  localparam int IDLE_LIMIT = 6000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [ppc_pkg::CFG_IW-1:0]   cfg_index_i = '0;
  logic [ppc_pkg::CFG_DW-1:0]   cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [2:0]                   cmd_i = '0;
  logic [ppc_pkg::NS_W-1:0]     now_ns_i = '0;
  logic [ppc_pkg::POS_W-1:0]    position_us_i = '0;
  logic [ppc_pkg::CNT_W-1:0]    sample_count_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [ppc_pkg::POS_W-1:0]    time_us_o;
  logic                         is_answer_o;
  logic                         running_now_o;

  int          fail_count, pending;
  int          n_items = 0, n_phases = 0, burst_left = 0, idle_cycles = 0;
  int          hold_left = 0, rx_cycle = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  logic [62:0] wall = '0;

  always #5 clk_i = ~clk_i;

  playback_position_clock u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .cmd_i, .now_ns_i, .position_us_i, .sample_count_i,
    .out_valid_o, .out_ready_i, .time_us_o, .is_answer_o, .running_now_o
  );

  ppc_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .now_ns_i, .position_us_i,
    .sample_count_i, .out_valid_i(out_valid_o), .out_ready_i, .time_us_i(time_us_o),
    .is_answer_i(is_answer_o), .running_now_i(running_now_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: one long hold on request, otherwise a rotating stall pattern
  always @(negedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      case ((rx_cycle / 250) % 3)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 1) == 1);
        default: out_ready_i <= (rx_cycle % 4 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_cmd(input ppc_pkg::cmd_e c, input logic [62:0] t,
                          input logic [47:0] p, input logic [15:0] n);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i = 1'b1;
    cmd_i = c;
    now_ns_i = t;
    position_us_i = p;
    sample_count_i = n;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    n_items++;
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [ppc_pkg::CFG_IW-1:0] idx,
                           input logic [ppc_pkg::CFG_DW-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [62:0] step_wall();
    int k;
    k = $urandom_range(0, 99);
    if (k < 80) wall = wall + 63'($urandom_range(0, 60_000_000));
    else if (k < 90) wall = wall + 63'({$urandom_range(0, 255), $urandom});
    else if (k < 95) wall = wall - 63'($urandom_range(0, 1_000_000_000));
    else wall = 63'({$urandom, $urandom});
    return wall;
  endfunction

  function automatic logic [47:0] pick_pos();
    int k;
    k = $urandom_range(0, 99);
    if (k < 80) return 48'($urandom_range(0, 400_000_000));
    if (k < 90) return 48'({$urandom, $urandom});
    return {1'b1, 47'({$urandom, $urandom})};
  endfunction

  function automatic logic [15:0] pick_count();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1) * 16'hFFFF)
                                       : 16'($urandom_range(0, 4096));
  endfunction

  task automatic random_cmd();
    send_cmd(ppc_pkg::cmd_e'($urandom_range(0, 7)), step_wall(), pick_pos(),
             16'($urandom));
  endtask

  // seek, start, a run of samples/syncs/reads, pause or stop, then maybe a restart and reads
  task automatic play_session();
    int steps, k;
    send_cmd(ppc_pkg::CMD_SEEK, step_wall(), pick_pos(), '0);
    send_cmd(ppc_pkg::CMD_START, step_wall(), '0, '0);
    steps = $urandom_range(4, 20);
    repeat (steps) begin
      k = $urandom_range(0, 9);
      if (k < 3) send_cmd(ppc_pkg::CMD_SAMPLES, step_wall(), '0, pick_count());
      else if (k < 5) send_cmd(ppc_pkg::CMD_SYNC, step_wall(), pick_pos(), '0);
      else if (k < 8) send_cmd(ppc_pkg::CMD_READ_CUR, step_wall(), '0, '0);
      else send_cmd(ppc_pkg::CMD_READ_PROD, step_wall(), '0, '0);
    end
    send_cmd(($urandom_range(0, 1) == 1) ? ppc_pkg::CMD_PAUSE : ppc_pkg::CMD_STOP,
             step_wall(), '0, '0);
    if ($urandom_range(0, 1) == 1) begin
      send_cmd(ppc_pkg::CMD_START, step_wall(), '0, '0);
      send_cmd(ppc_pkg::CMD_READ_CUR, step_wall(), '0, '0);
      send_cmd(ppc_pkg::CMD_READ_PROD, step_wall(), '0, '0);
    end
  endtask

  task automatic run_random(input int quota);
    int target;
    target = n_items + quota;
    while (n_items < target) begin
      if ($urandom_range(0, 9) == 0) random_cmd();
      else play_session();
      if (n_items > 500 && n_phases == 2 && !hold_req) begin
        hold_req = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: field extremes, stopped-state commands, time before start/anchor
    send_cmd(ppc_pkg::CMD_SEEK, '0, 48'h7FFF_FFFF_FFFF, '0);
    send_cmd(ppc_pkg::CMD_READ_CUR, '0, '0, '0);
    send_cmd(ppc_pkg::CMD_SEEK, '0, 48'h8000_0000_0000, 16'hFFFF);
    send_cmd(ppc_pkg::CMD_SEEK, '0, 48'd1_000_000, '0);
    send_cmd(ppc_pkg::CMD_PAUSE, 63'd5, '0, '0);
    send_cmd(ppc_pkg::CMD_STOP, 63'd6, '0, '0);
    send_cmd(ppc_pkg::CMD_READ_PROD, 63'd7, '0, '0);
    send_cmd(ppc_pkg::CMD_START, 63'd1_000_000_000, '0, '0);
    send_cmd(ppc_pkg::CMD_READ_CUR, 63'd900_000_000, '0, '0);
    send_cmd(ppc_pkg::CMD_READ_CUR, 63'd1_400_000_000, '0, '0);
    send_cmd(ppc_pkg::CMD_READ_CUR, 63'd3_000_000_000, '0, '0);
    send_cmd(ppc_pkg::CMD_SAMPLES, 63'd3_000_000_000, '0, 16'hFFFF);
    send_cmd(ppc_pkg::CMD_SAMPLES, 63'd3_000_000_000, '0, '0);
    send_cmd(ppc_pkg::CMD_READ_PROD, 63'd3_000_000_000, '0, '0);
    send_cmd(ppc_pkg::CMD_SYNC, 63'd4_000_000_000, 48'hFFFF_FFFF_FFFF, '0);
    send_cmd(ppc_pkg::CMD_READ_CUR, 63'd3_500_000_000, '0, '0);
    send_cmd(ppc_pkg::CMD_SYNC, 63'd4_000_000_000, 48'h7FFF_FFFF_0000, '0);
    send_cmd(ppc_pkg::CMD_READ_CUR, 63'h7FFF_FFFF_FFFF_FFFF, '0, '0);
    send_cmd(ppc_pkg::CMD_PAUSE, 63'h7FFF_FFFF_FFFF_FFFF, '0, '0);
    send_cmd(ppc_pkg::CMD_START, 63'h7FFF_FFFF_FFFF_FFF0, '0, '0);
    send_cmd(ppc_pkg::CMD_READ_CUR, 63'h7FFF_FFFF_FFFF_FFFF, '0, '0);
    send_cmd(ppc_pkg::CMD_READ_PROD, 63'h7FFF_FFFF_FFFF_FFFF, '0, '0);
    send_cmd(ppc_pkg::CMD_STOP, 63'h7FFF_FFFF_FFFF_FFFF, '0, '0);
    wall = 63'd10_000_000_000;

    run_random(215);
    n_phases++;

    // sender waits out every result before the config change
    drain();
    write_reg(ppc_pkg::CFG_SAMPLE_RATE, 32'd1);
    write_reg(ppc_pkg::CFG_RATE, 32'd410);
    write_reg(ppc_pkg::CFG_GRACE, 32'd0);
    run_random(215);
    n_phases++;

    drain();
    write_reg(ppc_pkg::CFG_SAMPLE_RATE, 32'd768000);
    write_reg(ppc_pkg::CFG_RATE, 32'd32768);
    write_reg(ppc_pkg::CFG_GRACE, 32'hFFFF_FFFF);
    run_random(215);
    n_phases++;

    drain();
    write_reg(ppc_pkg::CFG_SAMPLE_RATE, 32'd0);
    write_reg(ppc_pkg::CFG_RATE, 32'd0);
    write_reg(ppc_pkg::CFG_GRACE, 32'd1_000_000);
    run_random(185);
    n_phases++;

    drain();
    write_reg(ppc_pkg::CFG_SAMPLE_RATE, 32'hFFFF_FFFF);
    write_reg(ppc_pkg::CFG_RATE, 32'hFFFF_FFFF);
    write_reg(ppc_pkg::CFG_GRACE, 32'd250_000_000);
    write_reg(2'd3, 32'hA5A5_A5A5);
    run_random(110);
    drain();
    write_reg(ppc_pkg::CFG_SAMPLE_RATE, 32'd44100);
    write_reg(ppc_pkg::CFG_RATE, 32'd6144);
    run_random(110);
    n_phases++;

    drain();
    $display("Sent %0d command items across %0d config phases, including a long output hold.",
             n_items, n_phases);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ppc_pkg.sv
sv/ppc_front.sv
sv/ppc_fifo.sv
sv/ppc_back.sv
sv/playback_position_clock.sv
sim/ppc_checker.sv
sim/playback_position_clock_tb.sv
